// File: rtl/cmas_pkg.sv
// Shared types and constants for the 8-bit move/add/subtract unit.
// Used by every module of the block; depends on nothing.
package cmas_pkg;

    localparam int DATA_W  = 8;
    localparam int ADDR_W  = 16;
    localparam int CYC_W   = 32;
    localparam int ADD_W   = 3;
    localparam int RIDX_W  = 3;
    localparam int NUM_REGS = 7;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 72;

    localparam logic [RIDX_W-1:0] REG_H = 3'd4;
    localparam logic [RIDX_W-1:0] REG_L = 3'd5;
    localparam logic [RIDX_W-1:0] REG_A = 3'd6;
    localparam logic [2:0]        CODE_MEM = 3'd6;
    localparam logic [2:0]        CODE_A   = 3'd7;

    localparam logic [7:0] OP_HALT_SLOT = 8'h76;

    localparam logic [2:0] K_MOVE  = 3'd0;
    localparam logic [2:0] K_LOAD  = 3'd1;
    localparam logic [2:0] K_STORE = 3'd2;
    localparam logic [2:0] K_ALU_R = 3'd3;
    localparam logic [2:0] K_ALU_M = 3'd4;
    localparam logic [2:0] K_BAD   = 3'd5;

    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_ADC = 2'd1;
    localparam logic [1:0] ALU_SUB = 2'd2;
    localparam logic [1:0] ALU_SBB = 2'd3;

    localparam logic [ADD_W-1:0] CYC_MOVE  = 3'd5;
    localparam logic [ADD_W-1:0] CYC_MEM   = 3'd7;
    localparam logic [ADD_W-1:0] CYC_ALU_R = 3'd4;
    localparam logic [ADD_W-1:0] CYC_NONE  = 3'd0;

    // result packing offsets, lowest bit first
    localparam int O_WR   = 0;
    localparam int O_ADDR = 1;
    localparam int O_WDAT = 17;
    localparam int O_ACC  = 25;
    localparam int O_S    = 33;
    localparam int O_Z    = 34;
    localparam int O_AC   = 35;
    localparam int O_P    = 36;
    localparam int O_CY   = 37;
    localparam int O_CYC  = 38;
    localparam int O_BAD  = 70;

    typedef struct packed {
        logic [2:0]        kind;
        logic [RIDX_W-1:0] src;
        logic [RIDX_W-1:0] dst;
        logic [1:0]        alu_op;
        logic [DATA_W-1:0] mem;
        logic [ADD_W-1:0]  cyc_add;
    } t_instr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [RIDX_W-1:0] code_to_reg(input logic [2:0] code);
        logic [RIDX_W-1:0] idx;
        idx = (code == CODE_A) ? REG_A : code;
        return idx;
    endfunction

endpackage

// File: rtl/cmas_front.sv
// Front end: accepts opcode items and classifies them into decoded requests.
// Depends on cmas_pkg.
module cmas_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [cmas_pkg::S_TDATA_W-1:0]   i_data,
    output logic                             o_push,
    output cmas_pkg::t_instr                 o_instr,
    input  cmas_pkg::t_q_status              i_q_status
);

    logic            r_valid;
    cmas_pkg::t_instr r_instr;
    cmas_pkg::t_instr n_instr;
    logic [7:0]      w_op;
    logic [2:0]      w_dcode;
    logic [2:0]      w_scode;

    assign w_op    = i_data[7:0];
    assign w_dcode = w_op[5:3];
    assign w_scode = w_op[2:0];

    always_comb begin
        n_instr.src     = cmas_pkg::code_to_reg(w_scode);
        n_instr.dst     = cmas_pkg::code_to_reg(w_dcode);
        n_instr.alu_op  = w_op[4:3];
        n_instr.mem     = i_data[15:8];
        n_instr.kind    = cmas_pkg::K_BAD;
        n_instr.cyc_add = cmas_pkg::CYC_NONE;
        if (w_op[7:6] == 2'b01 && w_op != cmas_pkg::OP_HALT_SLOT) begin
            if (w_dcode == cmas_pkg::CODE_MEM) begin
                n_instr.kind    = cmas_pkg::K_STORE;
                n_instr.cyc_add = cmas_pkg::CYC_MEM;
            end else if (w_scode == cmas_pkg::CODE_MEM) begin
                n_instr.kind    = cmas_pkg::K_LOAD;
                n_instr.cyc_add = cmas_pkg::CYC_MEM;
            end else begin
                n_instr.kind    = cmas_pkg::K_MOVE;
                n_instr.cyc_add = cmas_pkg::CYC_MOVE;
            end
        end else if (w_op[7:5] == 3'b100) begin
            if (w_scode == cmas_pkg::CODE_MEM) begin
                n_instr.kind    = cmas_pkg::K_ALU_M;
                n_instr.cyc_add = cmas_pkg::CYC_MEM;
            end else begin
                n_instr.kind    = cmas_pkg::K_ALU_R;
                n_instr.cyc_add = cmas_pkg::CYC_ALU_R;
            end
        end
    end

    assign o_push  = r_valid && !i_q_status.full;
    assign o_ready = !r_valid || !i_q_status.full;
    assign o_instr = r_instr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_instr <= n_instr;
        end
    end

endmodule

// File: rtl/cmas_queue.sv
// Short queue of decoded requests between front end and execute stage.
// Depends on cmas_pkg.
module cmas_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cmas_pkg::t_instr    i_instr,
    input  logic                i_pop,
    output cmas_pkg::t_instr    o_instr,
    output cmas_pkg::t_q_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    cmas_pkg::t_instr  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_push;
    logic              w_pop;

    assign o_status.full  = (r_count == FULL);
    assign o_status.empty = (r_count == '0);
    assign w_push  = i_push && !o_status.full;
    assign w_pop   = i_pop && !o_status.empty;
    assign o_instr = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_instr;
        end
    end

endmodule

// File: rtl/cmas_back.sv
// Execute stage: register file, flags, cycle total and the result register.
// Depends on cmas_pkg.
module cmas_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cmas_pkg::t_instr                 i_instr,
    input  cmas_pkg::t_q_status              i_q_status,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [cmas_pkg::M_TDATA_W-1:0]   o_data
);

    logic [cmas_pkg::DATA_W-1:0] r_regs [cmas_pkg::NUM_REGS];
    logic [cmas_pkg::DATA_W-1:0] n_regs [cmas_pkg::NUM_REGS];
    logic [4:0]                  r_flags;
    logic [4:0]                  n_flags;
    logic [cmas_pkg::CYC_W-1:0]  r_cyc;
    logic [cmas_pkg::CYC_W-1:0]  n_cyc;
    logic                        r_valid;
    logic [cmas_pkg::M_TDATA_W-1:0] r_data;
    logic [cmas_pkg::M_TDATA_W-1:0] n_data;

    logic [cmas_pkg::DATA_W-1:0] w_src_val;
    logic [cmas_pkg::DATA_W-1:0] w_a;
    logic [cmas_pkg::DATA_W-1:0] w_b;
    logic                        w_cin;
    logic [8:0]                  w_sum;
    logic [8:0]                  w_diff;
    logic [4:0]                  w_nsum;
    logic [4:0]                  w_ndiff;
    logic [cmas_pkg::DATA_W-1:0] w_res;
    logic                        w_is_sub;
    logic                        w_wr;
    logic [cmas_pkg::DATA_W-1:0] w_wdata;

    assign o_pop   = !i_q_status.empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    assign w_src_val = r_regs[i_instr.src];
    assign w_a       = r_regs[cmas_pkg::REG_A];
    assign w_b       = (i_instr.kind == cmas_pkg::K_ALU_M) ? i_instr.mem : w_src_val;
    assign w_cin     = i_instr.alu_op[0] & r_flags[0];
    assign w_is_sub  = i_instr.alu_op[1];
    assign w_sum     = {1'b0, w_a} + {1'b0, w_b} + {8'd0, w_cin};
    assign w_diff    = {1'b0, w_a} - {1'b0, w_b} - {8'd0, w_cin};
    assign w_nsum    = {1'b0, w_a[3:0]} + {1'b0, w_b[3:0]} + {4'd0, w_cin};
    assign w_ndiff   = {1'b0, w_a[3:0]} - {1'b0, w_b[3:0]} - {4'd0, w_cin};
    assign w_res     = w_is_sub ? w_diff[7:0] : w_sum[7:0];

    // flags packed as {S, Z, AC, P, CY}
    always_comb begin
        for (int i = 0; i < cmas_pkg::NUM_REGS; i++) begin
            n_regs[i] = r_regs[i];
        end
        n_flags = r_flags;
        n_cyc   = r_cyc + {{(cmas_pkg::CYC_W - cmas_pkg::ADD_W){1'b0}}, i_instr.cyc_add};
        w_wr    = 1'b0;
        w_wdata = '0;
        case (i_instr.kind)
            cmas_pkg::K_MOVE: begin
                n_regs[i_instr.dst] = w_src_val;
            end
            cmas_pkg::K_LOAD: begin
                n_regs[i_instr.dst] = i_instr.mem;
            end
            cmas_pkg::K_STORE: begin
                w_wr    = 1'b1;
                w_wdata = w_src_val;
            end
            cmas_pkg::K_ALU_R, cmas_pkg::K_ALU_M: begin
                n_regs[cmas_pkg::REG_A] = w_res;
                n_flags = {w_res[7], (w_res == '0),
                           w_is_sub ? w_ndiff[4] : w_nsum[4],
                           ~(^w_res),
                           w_is_sub ? w_diff[8] : w_sum[8]};
            end
            default: begin
                n_cyc = r_cyc;
            end
        endcase
        n_data = '0;
        n_data[cmas_pkg::O_WR] = w_wr;
        n_data[cmas_pkg::O_ADDR +: cmas_pkg::ADDR_W] =
            {r_regs[cmas_pkg::REG_H], r_regs[cmas_pkg::REG_L]};
        n_data[cmas_pkg::O_WDAT +: cmas_pkg::DATA_W] = w_wdata;
        n_data[cmas_pkg::O_ACC +: cmas_pkg::DATA_W]  = n_regs[cmas_pkg::REG_A];
        n_data[cmas_pkg::O_S]  = n_flags[4];
        n_data[cmas_pkg::O_Z]  = n_flags[3];
        n_data[cmas_pkg::O_AC] = n_flags[2];
        n_data[cmas_pkg::O_P]  = n_flags[1];
        n_data[cmas_pkg::O_CY] = n_flags[0];
        n_data[cmas_pkg::O_CYC +: cmas_pkg::CYC_W] = n_cyc;
        n_data[cmas_pkg::O_BAD] = (i_instr.kind == cmas_pkg::K_BAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cmas_pkg::NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
            r_flags <= '0;
            r_cyc   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                for (int i = 0; i < cmas_pkg::NUM_REGS; i++) begin
                    r_regs[i] <= n_regs[i];
                end
                r_flags <= n_flags;
                r_cyc   <= n_cyc;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

endmodule

// File: rtl/cpu8_move_add_sub_unit.sv
// Top level of the 8-bit move/add/subtract unit: front end, request queue, execute stage.
// An accepted opcode passes the front-end register, the queue and the result register in turn.
// Throughput: one opcode per cycle while m_axis_tready is high, set by the result register.
// Reset: synchronous, active low; registers, flags and cycle total clear to zero, queue empties.
// Depends on cmas_pkg, cmas_front, cmas_queue and cmas_back.
module cpu8_move_add_sub_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // opcode[7:0], mem_operand[15:8]
    input  logic [cmas_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // mem_write[0], mem_addr[16:1], mem_wdata[24:17], acc_value[32:25], sign_flag[33],
    // zero_flag[34], aux_carry_flag[35], parity_flag[36], carry_flag[37],
    // cycle_total[69:38], unsupported[70], zero pad[71]
    output logic [cmas_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    logic                q_push;
    logic                q_pop;
    cmas_pkg::t_instr    q_in;
    cmas_pkg::t_instr    q_out;
    cmas_pkg::t_q_status q_status;

    cmas_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_data     (s_axis_tdata),
        .o_push     (q_push),
        .o_instr    (q_in),
        .i_q_status (q_status)
    );

    cmas_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_instr  (q_in),
        .i_pop    (q_pop),
        .o_instr  (q_out),
        .o_status (q_status)
    );

    cmas_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_instr    (q_out),
        .i_q_status (q_status),
        .o_pop      (q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !q_push)
        else $error("push into full request queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.empty |-> !q_pop)
        else $error("pop from empty request queue");

    a_bad_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[cmas_pkg::O_BAD]) |-> !m_axis_tdata[cmas_pkg::O_WR])
        else $error("unsupported opcode reported a memory write");

    a_wdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[cmas_pkg::O_WR])
            |-> (m_axis_tdata[cmas_pkg::O_WDAT +: cmas_pkg::DATA_W] == '0))
        else $error("write data nonzero without a memory write");
`endif

endmodule
